// File: design/cbrw_pkg.sv
// Shared types and constants for the comm board register window.
// Depends on nothing; imported by the top level.
`default_nettype none
package cbrw_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int S_DATA_W      = 24;
  localparam int M_DATA_W      = 32;
  localparam int CFG_DATA_W    = 8;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_CONTROL  = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_DATA     = 3'd2,
    REG_STATUS0  = 3'd3,
    REG_STATUS1  = 3'd4,
    REG_UNMAPPED = 3'd5
  } reg_sel_t;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_NODE_ID    = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD1,
    ST_RD2,
    ST_WR1,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_HDR3,
    ST_FILL,
    ST_DONE
  } state_t;

  localparam int CTRL_CPU_BIT   = 0;
  localparam int CTRL_RESET_BIT = 5;

  localparam logic [15:0] STATUS_LINKED = 16'hFF01;
  localparam logic [15:0] KEY_MASTER    = 16'h7830;
  localparam logic [15:0] KEY_SLAVE     = 16'h73A2;
  localparam logic [15:0] SLOT_ADDR     = 16'h0204;
  localparam logic [15:0] HDR_BASE      = 16'hF000;
  localparam logic [15:0] SLOT_BASE     = 16'h0100;
  localparam logic [31:0] UNMAPPED_VAL  = 32'hFFFF_FFFF;

  localparam logic [5:0] FILL_HDR_FIRST = 6'd0;
  localparam logic [5:0] FILL_BLK_FIRST = 6'd16;
  localparam logic [5:0] FILL_LAST      = 6'd47;

endpackage
`default_nettype wire

// File: design/cbrw_ram.sv
// Generic single-port-write, registered-read RAM.
// Stand-alone; instanced for comm RAM and CPU RAM.
`default_nettype none
module cbrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/comm_board_register_window_unit.sv
// Comm board host register window: registers, data port, board-reset fill.
// Uses cbrw_pkg and two cbrw_ram byte memories (comm RAM, CPU RAM).
//
//  channel | signals                         | contents
//  s       | s_tvalid s_tready s_tdata[23:0] | operation, register_select, write_value
//  m       | m_tvalid m_tready m_tdata[31:0] | read_value
//  cfg     | cfg_we cfg_index cfg_data[7:0]  | node_count (0), node_id (1)
//
// A register request completes in EXEC; a data port write or read makes two byte
// RAM operations through the single RAM port, then the result register.
// A board-reset control write fills 32 bytes of comm RAM, or 48 with two or more nodes
// (CPU RAM slot read, multiply, then one byte write per cycle). Reset clears control,
// offset, status, node config, state and m_tvalid; RAM contents are undefined until written.
// One output register lets the next request be taken while a result waits.
`default_nettype none
module comm_board_register_window_unit
  #(
  parameter int ADDR_BITS = cbrw_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [0] operation, [3:1] register_select, [19:4] write_value, [23:20] zero
  input  wire logic [cbrw_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] read_value
  output logic      [cbrw_pkg::M_DATA_W-1:0]   m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [cbrw_pkg::CFG_DATA_W-1:0] cfg_data
);

  import cbrw_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  state_t       state, state_next;
  op_t          op_q;
  reg_sel_t     sel_q;
  logic [15:0]  wv_q;
  logic [7:0]   node_count, node_id;
  logic [15:0]  control_word, access_offset, status_low, status_high;
  logic [7:0]   hi_byte;
  logic [15:0]  slot, total;
  logic [23:0]  prod;
  logic [5:0]   fill_idx;
  logic         linked;
  logic [31:0]  res;

  logic [15:0]  ram_addr;
  logic [7:0]   ram_wdata, comm_rdata, cpu_rdata, rdata;
  logic         comm_we, cpu_we, use_cpu, slot_free, deliver, reset_edge;
  logic [31:0]  deliver_val;

  function automatic logic [7:0] fill_byte(input logic [5:0] idx, input logic lnk,
                                           input logic [15:0] s, input logic [15:0] tot,
                                           input logic [7:0] n, input logic [7:0] id);
    logic [4:0]  j;
    logic [15:0] key, sb;
    logic [7:0]  b;
    j   = 5'(idx - FILL_BLK_FIRST);
    key = (id == 8'd0) ? KEY_MASTER : KEY_SLAVE;
    sb  = s + SLOT_BASE;
    b   = 8'd0;
    if (idx < FILL_BLK_FIRST) begin
      case (idx[3:0])
        4'd0, 4'd1: b = 8'd1;
        4'd2:       b = s[15:8];
        4'd3:       b = s[7:0];
        default:    b = 8'd0;
      endcase
    end else if (lnk) begin
      case (j)
        5'd1:        b = {7'd0, id != 8'd0};
        5'd2, 5'd3:  b = n;
        5'd4, 5'd5:  b = id;
        5'd8:        b = key[15:8];
        5'd9:        b = key[7:0];
        5'd10:       b = sb[15:8];
        5'd11:       b = sb[7:0];
        5'd12, 5'd16: b = tot[15:8];
        5'd13, 5'd17: b = tot[7:0];
        5'd14:       b = SLOT_BASE[15:8];
        5'd15:       b = SLOT_BASE[7:0];
        default:     b = 8'd0;
      endcase
    end
    return b;
  endfunction

  cbrw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_comm_ram (
    .clk   (clk),
    .we    (comm_we),
    .waddr (ram_addr[ADDR_BITS-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_addr[ADDR_BITS-1:0]),
    .rdata (comm_rdata)
  );

  cbrw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_cpu_ram (
    .clk   (clk),
    .we    (cpu_we),
    .waddr (ram_addr[ADDR_BITS-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_addr[ADDR_BITS-1:0]),
    .rdata (cpu_rdata)
  );

  assign s_tready   = (state == ST_IDLE);
  assign slot_free  = !m_tvalid || m_tready;
  assign reset_edge = !control_word[CTRL_RESET_BIT] && wv_q[CTRL_RESET_BIT];
  assign rdata      = use_cpu ? cpu_rdata : comm_rdata;
  assign prod       = slot * node_count;

  always_comb begin
    state_next  = state;
    ram_addr    = access_offset;
    ram_wdata   = wv_q[15:8];
    comm_we     = 1'b0;
    cpu_we      = 1'b0;
    use_cpu     = control_word[CTRL_CPU_BIT];
    deliver     = 1'b0;
    deliver_val = 32'd0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sel_q == REG_DATA) begin
          if (op_q == OP_WRITE) begin
            comm_we    = !use_cpu;
            cpu_we     = use_cpu;
            state_next = ST_WR1;
          end else begin
            state_next = ST_RD1;
          end
        end else if (op_q == OP_WRITE && sel_q == REG_CONTROL && reset_edge) begin
          state_next = (node_count >= 8'd2) ? ST_HDR0 : ST_FILL;
        end else if (slot_free) begin
          deliver = 1'b1;
          if (op_q == OP_READ) begin
            case (sel_q)
              REG_CONTROL: deliver_val = {16'd0, control_word};
              REG_OFFSET:  deliver_val = {16'd0, access_offset};
              REG_STATUS0: deliver_val = {16'd0, status_low};
              REG_STATUS1: deliver_val = {16'd0, status_high};
              default:     deliver_val = UNMAPPED_VAL;
            endcase
          end
          state_next = ST_IDLE;
        end
      end
      ST_RD1: begin
        ram_addr   = access_offset + 16'd1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        state_next = ST_DONE;
      end
      ST_WR1: begin
        ram_addr   = access_offset + 16'd1;
        ram_wdata  = wv_q[7:0];
        comm_we    = !use_cpu;
        cpu_we     = use_cpu;
        state_next = ST_DONE;
      end
      ST_HDR0: begin
        ram_addr   = SLOT_ADDR;
        use_cpu    = 1'b1;
        state_next = ST_HDR1;
      end
      ST_HDR1: begin
        ram_addr   = SLOT_ADDR + 16'd1;
        use_cpu    = 1'b1;
        state_next = ST_HDR2;
      end
      ST_HDR2: begin
        use_cpu    = 1'b1;
        state_next = ST_HDR3;
      end
      ST_HDR3: begin
        state_next = ST_FILL;
      end
      ST_FILL: begin
        ram_addr  = (fill_idx < FILL_BLK_FIRST) ? (HDR_BASE + {12'd0, fill_idx[3:0]})
                                                : {11'd0, 5'(fill_idx - FILL_BLK_FIRST)};
        ram_wdata = fill_byte(fill_idx, linked, slot, total, node_count, node_id);
        comm_we   = 1'b1;
        if (fill_idx == FILL_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          deliver     = 1'b1;
          deliver_val = res;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 8'd0;
      node_id    <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NODE_COUNT: node_count <= cfg_data;
        CFG_NODE_ID:    node_id    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (deliver) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (deliver) begin
      m_tdata <= deliver_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word  <= 16'd0;
      access_offset <= 16'd0;
      status_low    <= 16'd0;
      status_high   <= 16'd0;
    end else begin
      case (state)
        ST_EXEC: begin
          if (op_q == OP_WRITE && sel_q == REG_CONTROL && reset_edge) begin
            control_word <= wv_q;
            status_low   <= 16'd0;
            status_high  <= 16'd0;
          end else if (op_q == OP_WRITE && slot_free) begin
            case (sel_q)
              REG_CONTROL: control_word  <= wv_q;
              REG_OFFSET:  access_offset <= wv_q;
              REG_STATUS0: status_low    <= wv_q;
              REG_STATUS1: status_high   <= wv_q;
              default: ;
            endcase
          end
        end
        ST_RD2, ST_WR1: access_offset <= access_offset + 16'd2;
        ST_FILL: begin
          if (fill_idx == FILL_LAST && linked) begin
            status_low  <= STATUS_LINKED;
            status_high <= {node_count, node_id};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q  <= op_t'(s_tdata[0]);
      sel_q <= reg_sel_t'(s_tdata[3:1]);
      wv_q  <= s_tdata[19:4];
    end
    case (state)
      ST_EXEC: begin
        res      <= 32'd0;
        linked   <= (node_count >= 8'd2);
        fill_idx <= (node_count >= 8'd2) ? FILL_HDR_FIRST : FILL_BLK_FIRST;
      end
      ST_RD1:  hi_byte <= rdata;
      ST_RD2:  res     <= {16'd0, hi_byte, rdata};
      ST_HDR1: hi_byte <= rdata;
      ST_HDR2: slot    <= {hi_byte, rdata};
      ST_HDR3: total   <= prod[15:0];
      ST_FILL: fill_idx <= fill_idx + 6'd1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: bench/tb_comm_board_register_window_unit.sv
// Testbench for comm_board_register_window_unit: directed and random register and data port
// requests, checked against a behavioural mirror of the registers and both byte RAMs.
// Depends on cbrw_pkg and the design sources only.
module tb_comm_board_register_window_unit;
  import cbrw_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    op_t         op;
    reg_sel_t    sel;
    logic [31:0] value;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_NODE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mirror of the window
  logic [15:0] ctrl_q = '0;
  logic [15:0] offset_q = '0;
  logic [15:0] status0_q = '0;
  logic [15:0] status1_q = '0;
  logic [7:0]  ring_count = '0;
  logic [7:0]  ring_id = '0;
  logic [7:0]  comm_mem [0:65535];
  logic [7:0]  cpu_mem [0:65535];
  bit          comm_set [0:65535];
  bit          cpu_set [0:65535];

  reply_t pending [$];
  int     errors = 0;
  int     cycles = 0;
  int     sent = 0;
  bit     steady = 1'b0;

  comm_board_register_window_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= steady || ($urandom_range(0, 99) >= 6);

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    reply_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending.size() == 0) begin
        report_mismatch("result with no request waiting", m_tdata, 'x);
      end else begin
        want = pending.pop_front();
        if (m_tdata !== want.value)
          report_mismatch($sformatf("read_value (%s %s)", want.op.name(), want.sel.name()),
                          m_tdata, want.value);
      end
    end
  end

  function automatic void mem_put(bit cpu, logic [15:0] addr, logic [15:0] v);
    logic [15:0] next_addr;
    next_addr = addr + 16'd1;
    if (cpu) begin
      cpu_mem[addr] = v[15:8];
      cpu_mem[next_addr] = v[7:0];
      cpu_set[addr] = 1'b1;
      cpu_set[next_addr] = 1'b1;
    end else begin
      comm_mem[addr] = v[15:8];
      comm_mem[next_addr] = v[7:0];
      comm_set[addr] = 1'b1;
      comm_set[next_addr] = 1'b1;
    end
  endfunction

  function automatic logic [15:0] mem_get(bit cpu, logic [15:0] addr);
    logic [15:0] next_addr;
    next_addr = addr + 16'd1;
    return cpu ? {cpu_mem[addr], cpu_mem[next_addr]} : {comm_mem[addr], comm_mem[next_addr]};
  endfunction

  function automatic bit word_known(bit cpu, logic [15:0] addr);
    logic [15:0] next_addr;
    next_addr = addr + 16'd1;
    return cpu ? (cpu_set[addr] && cpu_set[next_addr]) : (comm_set[addr] && comm_set[next_addr]);
  endfunction

  // rising edge of the board reset bit
  function automatic void board_reset_fill();
    logic [15:0] slot;
    logic [15:0] total;
    for (int i = 0; i < 32; i++) begin
      comm_mem[i] = 8'h00;
      comm_set[i] = 1'b1;
    end
    status0_q = '0;
    status1_q = '0;
    if (ring_count >= 2) begin
      slot = mem_get(1'b1, SLOT_ADDR);
      total = slot * ring_count;
      for (int i = 0; i < 16; i++) begin
        comm_mem[HDR_BASE + i] = 8'h00;
        comm_set[HDR_BASE + i] = 1'b1;
      end
      comm_mem[HDR_BASE] = 8'h01;
      comm_mem[HDR_BASE + 1] = 8'h01;
      comm_mem[HDR_BASE + 2] = cpu_mem[SLOT_ADDR];
      comm_mem[HDR_BASE + 3] = cpu_mem[SLOT_ADDR + 1];
      for (int i = 0; i < 32; i++) comm_mem[i] = 8'h00;
      mem_put(1'b0, 16'd0, {15'd0, ring_id != 8'd0});
      mem_put(1'b0, 16'd2, {ring_count, ring_count});
      mem_put(1'b0, 16'd4, {ring_id, ring_id});
      mem_put(1'b0, 16'd8, (ring_id == 8'd0) ? KEY_MASTER : KEY_SLAVE);
      mem_put(1'b0, 16'd10, SLOT_BASE + slot);
      mem_put(1'b0, 16'd12, total);
      mem_put(1'b0, 16'd14, SLOT_BASE);
      mem_put(1'b0, 16'd16, total);
      status0_q = STATUS_LINKED;
      status1_q = {ring_count, ring_id};
    end
  endfunction

  function automatic logic [31:0] window_access(op_t op, reg_sel_t sel, logic [15:0] wv);
    logic [31:0] rv;
    bit cpu;
    rv = '0;
    cpu = ctrl_q[CTRL_CPU_BIT];
    if (op == OP_READ) begin
      case (sel)
        REG_CONTROL: rv = {16'd0, ctrl_q};
        REG_OFFSET:  rv = {16'd0, offset_q};
        REG_DATA: begin
          rv = {16'd0, mem_get(cpu, offset_q)};
          offset_q = offset_q + 16'd2;
        end
        REG_STATUS0: rv = {16'd0, status0_q};
        REG_STATUS1: rv = {16'd0, status1_q};
        default:     rv = UNMAPPED_VAL;
      endcase
    end else begin
      case (sel)
        REG_CONTROL: begin
          if (!ctrl_q[CTRL_RESET_BIT] && wv[CTRL_RESET_BIT]) board_reset_fill();
          ctrl_q = wv;
        end
        REG_OFFSET: offset_q = wv;
        REG_DATA: begin
          mem_put(cpu, offset_q, wv);
          offset_q = offset_q + 16'd2;
        end
        REG_STATUS0: status0_q = wv;
        REG_STATUS1: status1_q = wv;
        default: ;
      endcase
    end
    return rv;
  endfunction

  task automatic send_request(op_t op, reg_sel_t sel, logic [15:0] wv);
    reply_t r;
    s_tdata <= {4'd0, wv, sel, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    r.op = op;
    r.sel = sel;
    r.value = window_access(op, sel, wv);
    pending.push_back(r);
    sent++;
    if (!steady && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // never read a RAM word that was not written
  task automatic read_data_guarded();
    if (word_known(ctrl_q[CTRL_CPU_BIT], offset_q))
      send_request(OP_READ, REG_DATA, 16'($urandom));
    else
      send_request(OP_WRITE, REG_DATA, 16'($urandom));
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_ring(logic [7:0] count, logic [7:0] id);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NODE_COUNT;
    cfg_data <= count;
    @(posedge clk);
    ring_count = count;
    cfg_index <= CFG_NODE_ID;
    cfg_data <= id;
    @(posedge clk);
    ring_id = id;
    cfg_we <= 1'b0;
  endtask

  task automatic test_registers();
    send_request(OP_READ, REG_CONTROL, 16'h0000);
    send_request(OP_READ, REG_UNMAPPED, 16'hFFFF);
    send_request(OP_WRITE, REG_UNMAPPED, 16'hFFFF);
    send_request(OP_WRITE, REG_STATUS0, 16'hFFFF);
    send_request(OP_READ, REG_STATUS0, 16'h0000);
    send_request(OP_WRITE, REG_STATUS1, 16'h0000);
    send_request(OP_READ, REG_STATUS1, 16'hFFFF);
    send_request(OP_WRITE, REG_CONTROL, 16'hFFDE);
    send_request(OP_READ, REG_CONTROL, 16'h0000);
  endtask

  task automatic test_data_port();
    send_request(OP_WRITE, REG_CONTROL, 16'h0001);
    send_request(OP_WRITE, REG_OFFSET, SLOT_ADDR);
    send_request(OP_WRITE, REG_DATA, 16'h0003);
    // odd offset at the top of the RAM: the word wraps to byte 0
    send_request(OP_WRITE, REG_OFFSET, 16'hFFFF);
    send_request(OP_WRITE, REG_DATA, 16'hA55A);
    send_request(OP_READ, REG_OFFSET, 16'h0000);
    send_request(OP_WRITE, REG_OFFSET, 16'hFFFF);
    read_data_guarded();
  endtask

  task automatic test_board_reset();
    wait_quiet();
    set_ring(8'd2, 8'd0);
    send_request(OP_WRITE, REG_CONTROL, 16'h0000);
    send_request(OP_WRITE, REG_CONTROL, 16'h0020);
    send_request(OP_READ, REG_STATUS0, 16'h0000);
    send_request(OP_WRITE, REG_OFFSET, HDR_BASE);
    read_data_guarded();
    send_request(OP_WRITE, REG_CONTROL, 16'h0020);
    wait_quiet();
    set_ring(8'd255, 8'd255);
    send_request(OP_WRITE, REG_CONTROL, 16'h0000);
    send_request(OP_WRITE, REG_CONTROL, 16'hFFFF);
    send_request(OP_READ, REG_STATUS1, 16'h0000);
  endtask

  task automatic data_burst();
    logic [15:0] base;
    logic [15:0] v;
    int n;
    case ($urandom_range(0, 4))
      0:       base = 16'($urandom_range(0, 40));
      1:       base = 16'(HDR_BASE + $urandom_range(0, 31));
      2:       base = 16'(16'hFFF8 + $urandom_range(0, 7));
      3:       base = 16'(SLOT_ADDR - 16'd4 + $urandom_range(0, 8));
      default: base = 16'($urandom);
    endcase
    if ($urandom_range(0, 1)) begin
      v = 16'($urandom);
      v[CTRL_RESET_BIT] = ctrl_q[CTRL_RESET_BIT];
      send_request(OP_WRITE, REG_CONTROL, v);
    end
    n = $urandom_range(1, 8);
    send_request(OP_WRITE, REG_OFFSET, base);
    repeat (n) send_request(OP_WRITE, REG_DATA, 16'($urandom));
    send_request(OP_WRITE, REG_OFFSET, base);
    repeat (n) read_data_guarded();
  endtask

  task automatic reset_sequence();
    logic [15:0] v;
    v = 16'($urandom);
    v[CTRL_RESET_BIT] = 1'b0;
    send_request(OP_WRITE, REG_CONTROL, v);
    v = 16'($urandom);
    v[CTRL_RESET_BIT] = 1'b1;
    v[CTRL_CPU_BIT] = 1'b0;
    send_request(OP_WRITE, REG_CONTROL, v);
    send_request(OP_READ, REG_STATUS0, 16'($urandom));
    send_request(OP_READ, REG_STATUS1, 16'($urandom));
    send_request(OP_WRITE, REG_OFFSET, 16'h0000);
    repeat (10) read_data_guarded();
    send_request(OP_WRITE, REG_OFFSET, HDR_BASE);
    repeat (2) read_data_guarded();
  endtask

  task automatic single_request();
    op_t op;
    reg_sel_t sel;
    op = op_t'($urandom_range(0, 1));
    sel = reg_sel_t'($urandom_range(0, 5));
    if (op == OP_READ && sel == REG_DATA)
      read_data_guarded();
    else
      send_request(op, sel, 16'($urandom));
  endtask

  task automatic test_random_traffic();
    logic [7:0] counts [8];
    logic [7:0] ids [8];
    int phase_end;
    int pick;
    counts = '{8'd0, 8'd1, 8'd2, 8'd2, 8'd255, 8'd3, 8'd0, 8'd2};
    ids = '{8'd0, 8'd7, 8'd0, 8'd1, 8'd255, 8'd0, 8'd0, 8'd255};
    counts[6] = 8'($urandom);
    ids[5] = 8'($urandom);
    ids[6] = 8'($urandom);
    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      set_ring(counts[p], ids[p]);
      steady = (p == 3);
      phase_end = sent + 160;
      while (sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) data_burst();
        else if (pick < 55) reset_sequence();
        else single_request();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_registers();
    test_data_port();
    test_board_reset();
    test_random_traffic();
    wait_quiet();
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: comm_board_register_window_unit.f
design/cbrw_pkg.sv
design/cbrw_ram.sv
design/comm_board_register_window_unit.sv
bench/tb_comm_board_register_window_unit.sv
